[rtl/max_priority_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the max priority queue checker
// Expect a clock named clk and an active-low reset named rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Next-cycle implication, checked also while reset is asserted.
`define MPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

[rtl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants shared by the max priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int DataWidth = 32;

  typedef logic signed [DataWidth-1:0] mpq_data_t;

  // Action codes of an input transaction
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mpq_status_t;

  typedef struct packed {
    logic      action;
    mpq_data_t value;
  } mpq_in_t;

  typedef struct packed {
    mpq_status_t status;
    mpq_data_t   removed_value;
    mpq_data_t   top_value;
    logic        top_valid;
    logic [3:0]  fill_count;
    logic        is_empty;
    logic        is_full;
  } mpq_out_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic      ins;
    logic      rem;
    mpq_data_t value;
  } mpq_cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/mpq_stream_if.sv]
// ----------------------------------------------------------------------------
// mpq_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/mpq_cell.sv]
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted queue: compares the broadcast value against its own
// entry and shifts toward either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell (
  input  wire logic                   clk,
  input  wire mpq_pkg::mpq_cell_ctrl_t ctrl,
  input  wire logic                   occupied,
  input  wire mpq_pkg::mpq_data_t     left_value,
  input  wire logic                   left_gt,
  input  wire mpq_pkg::mpq_data_t     right_value,
  output mpq_pkg::mpq_data_t          value,
  output mpq_pkg::mpq_data_t          value_nxt,
  output logic                        gt
);

  mpq_pkg::mpq_data_t value_r;

  // An empty slot ranks below any value; equal values stay ahead.
  assign gt = !occupied || (ctrl.value > value_r);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (gt) begin
        value_nxt = left_gt ? left_value : ctrl.value;
      end
    end else if (ctrl.rem) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

`default_nettype wire

[rtl/max_priority_queue.sv]
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max-priority queue of signed 32-bit values on a row of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per operation; action selects insert or remove
//            of the largest value, value is the operand of an insert.
//   out_ch : exactly one result per input transaction, in order: status,
//            removed value, largest remaining value with its valid flag,
//            fill count and empty/full flags.
//   The result is registered and valid in the cycle after input acceptance.
//   Throughput is one transaction per cycle while results are taken: every cell
//   compares the broadcast value with its own entry in parallel and shifts one
//   step toward a neighbor.
//   The cells stay sorted largest first, so the head cell is the top value.
//   Reset empties the queue (fill count zero) and drops any pending result;
//   no clearing pass is needed and in_ch is ready right after reset.
//   When the receiver stalls, the result is held and in_ch drops ready until
//   the pending result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module max_priority_queue #(
  parameter int CAPACITY = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mpq_stream_if.sink       in_ch,
  mpq_stream_if.source     out_ch
);

  localparam int CountWidth = $clog2(CAPACITY + 1);

  logic [CountWidth-1:0] count_r;
  logic [CountWidth-1:0] count_nxt;
  logic                  out_valid_r;
  mpq_pkg::mpq_out_t     out_data_r;
  mpq_pkg::mpq_out_t     out_data_nxt;

  logic                    in_fire;
  logic                    is_full_now;
  logic                    is_empty_now;
  mpq_pkg::mpq_cell_ctrl_t ctrl;

  mpq_pkg::mpq_data_t cell_value     [CAPACITY];
  mpq_pkg::mpq_data_t cell_value_nxt [CAPACITY];
  logic               cell_gt        [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign is_full_now  = (count_r == CountWidth'(CAPACITY));
  assign is_empty_now = (count_r == '0);

  assign ctrl.ins   = in_fire && (in_ch.data.action == mpq_pkg::ACT_INSERT) && !is_full_now;
  assign ctrl.rem   = in_fire && (in_ch.data.action == mpq_pkg::ACT_REMOVE) && !is_empty_now;
  assign ctrl.value = in_ch.data.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_pkg::mpq_data_t left_value;
    logic               left_gt;
    mpq_pkg::mpq_data_t right_value;

    if (i == 0) begin : g_head
      assign left_value = ctrl.value;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CountWidth'(i) < count_r),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .value_nxt   (cell_value_nxt[i]),
      .gt          (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CountWidth'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CountWidth'(1);
    end
  end

  always_comb begin
    out_data_nxt.status = mpq_pkg::ST_DONE;
    if (in_ch.data.action == mpq_pkg::ACT_INSERT) begin
      if (is_full_now) begin
        out_data_nxt.status = mpq_pkg::ST_FULL;
      end
    end else if (is_empty_now) begin
      out_data_nxt.status = mpq_pkg::ST_EMPTY;
    end
    out_data_nxt.removed_value = ctrl.rem ? cell_value[0] : '0;
    out_data_nxt.top_valid     = (count_nxt != '0);
    out_data_nxt.top_value     = out_data_nxt.top_valid ? cell_value_nxt[0] : '0;
    out_data_nxt.fill_count    = 4'(count_nxt);
    out_data_nxt.is_empty      = (count_nxt == '0);
    out_data_nxt.is_full       = (count_nxt == CountWidth'(CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload register: load with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

[rtl/mpq_checker.sv]
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_priority_queue_assert.svh"

module mpq_checker #(
  parameter int CAPACITY = 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire mpq_pkg::mpq_out_t out_data
);

  localparam logic [3:0] FullCount = 4'(CAPACITY);

  // A stalled result blocks new transactions
  `MPQ_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready)

  // Reset leaves no result pending
  `MPQ_ASSERT_NEXT(a_reset_clears_output, !rst_n, !out_valid)

  // A remove on empty reports an empty queue with nothing taken out
  `MPQ_ASSERT_SAME(a_empty_remove, out_valid && (out_data.status == mpq_pkg::ST_EMPTY),
                   out_data.is_empty && !out_data.top_valid && (out_data.removed_value == '0))

  // A dropped insert only happens on a full queue
  `MPQ_ASSERT_SAME(a_full_drop, out_valid && (out_data.status == mpq_pkg::ST_FULL),
                   out_data.is_full && (out_data.fill_count == FullCount))

endmodule

bind max_priority_queue mpq_checker #(
  .CAPACITY (CAPACITY)
) u_mpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Max priority queue testbench
// Sends insert and remove transactions through the input channel and
// checks every result against an in-bench model of the stored values.
// The stimulus starts with a few directed cases: extremes, ties, full and
// empty. Random phases with changing insert/remove mix and value styles
// follow. Both channels idle at random. The receiver holds off once for a
// long stretch, and the sender pauses until all results are back.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QueueDepth  = 8;
  localparam int NumPhases   = 29;
  localparam int PhaseLength = 50;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 80;

  // Tracks the stored values and predicts one status report per transaction
  class op_tracker;
    mpq_pkg::mpq_data_t held_values[$];
    mpq_pkg::mpq_out_t  expected_reports[$];
    int                 mismatches;
    int                 num_inserts;
    int                 num_removes;
    int                 num_full_drops;
    int                 num_empty_removes;
    int                 num_checked;

    function int largest_slot();
      int best;
      best = 0;
      for (int i = 1; i < held_values.size(); i++) begin
        if (held_values[i] > held_values[best]) best = i;
      end
      return best;
    endfunction

    function void apply_op(mpq_pkg::mpq_in_t op);
      mpq_pkg::mpq_out_t rpt;
      int                slot;
      rpt = '0;
      rpt.status = mpq_pkg::ST_DONE;
      if (op.action == mpq_pkg::ACT_INSERT) begin
        num_inserts++;
        if (held_values.size() >= QueueDepth) begin
          rpt.status = mpq_pkg::ST_FULL;
          num_full_drops++;
        end else begin
          held_values.push_back(op.value);
        end
      end else begin
        num_removes++;
        if (held_values.size() == 0) begin
          rpt.status = mpq_pkg::ST_EMPTY;
          num_empty_removes++;
        end else begin
          slot = largest_slot();
          rpt.removed_value = held_values[slot];
          held_values.delete(slot);
        end
      end
      if (held_values.size() > 0) begin
        rpt.top_value = held_values[largest_slot()];
        rpt.top_valid = 1'b1;
      end
      rpt.fill_count = 4'(held_values.size());
      rpt.is_empty   = (held_values.size() == 0);
      rpt.is_full    = (held_values.size() == QueueDepth);
      expected_reports.push_back(rpt);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      end
    endfunction

    function void check_report(mpq_pkg::mpq_out_t got);
      mpq_pkg::mpq_out_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        $error("result with no transaction outstanding");
        return;
      end
      want = expected_reports.pop_front();
      num_checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("removed_value", want.removed_value, got.removed_value);
      compare_field("top_value", want.top_value, got.top_value);
      compare_field("top_valid", 32'(want.top_valid), 32'(got.top_valid));
      compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
      compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   rx_hold_req;
  int   stall_cycles;
  int   hold_left;

  op_tracker tracker = new();

  mpq_stream_if #(.payload_t(mpq_pkg::mpq_in_t))  in_ch ();
  mpq_stream_if #(.payload_t(mpq_pkg::mpq_out_t)) out_ch ();

  max_priority_queue #(.CAPACITY(QueueDepth)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels and watch for a stuck run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.apply_op(in_ch.data);
      if (out_ch.valid && out_ch.ready) tracker.check_report(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_op(input logic act, input mpq_pkg::mpq_data_t val);
    mpq_pkg::mpq_in_t op;
    op.action = act;
    op.value  = val;
    if (!quiet && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= op;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.expected_reports.size() != 0) @(negedge clk);
  endtask

  initial begin
    int                 bias;
    int                 style;
    logic               act;
    mpq_pkg::mpq_data_t val;

    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty remove, extremes, ties, full drop, drain, empty remove, minimum insert and remove
    send_op(mpq_pkg::ACT_REMOVE, 32'sh7fffffff);
    send_op(mpq_pkg::ACT_INSERT, 32'sh7fffffff);
    send_op(mpq_pkg::ACT_INSERT, 32'sh80000000);
    send_op(mpq_pkg::ACT_INSERT, -32'sd1);
    send_op(mpq_pkg::ACT_INSERT, 32'sd0);
    send_op(mpq_pkg::ACT_INSERT, 32'sd5);
    send_op(mpq_pkg::ACT_INSERT, 32'sd5);
    send_op(mpq_pkg::ACT_INSERT, -32'sd1);
    send_op(mpq_pkg::ACT_INSERT, 32'sd1);
    send_op(mpq_pkg::ACT_INSERT, 32'sd42);
    repeat (QueueDepth) send_op(mpq_pkg::ACT_REMOVE, '0);
    send_op(mpq_pkg::ACT_REMOVE, -32'sd1);
    send_op(mpq_pkg::ACT_INSERT, 32'sh80000000);
    send_op(mpq_pkg::ACT_REMOVE, '0);
    wait_drained();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase % 5)
        0: bias = 50;
        1: bias = 80;
        2: bias = 20;
        3: bias = 95;
        default: bias = 5;
      endcase
      style = $urandom_range(3);
      quiet = (phase == 7 || phase == 8);
      if (phase == 4) begin
        // Hold off the receiver while inserts keep coming
        rx_hold_req = 1'b1;
        bias = 90;
      end
      for (int n = 0; n < PhaseLength; n++) begin
        act = ($urandom_range(99) < bias) ? mpq_pkg::ACT_INSERT : mpq_pkg::ACT_REMOVE;
        case (style)
          0: val = $urandom;
          1: val = $signed($urandom_range(8)) - 32'sd4;
          2: begin
            case ($urandom_range(5))
              0: val = 32'sh7fffffff;
              1: val = 32'sh80000000;
              2: val = 32'sh7ffffffe;
              3: val = 32'sh80000001;
              4: val = -32'sd1;
              default: val = 32'sd0;
            endcase
          end
          default: begin
            val = 32'sd1 <<< $urandom_range(31);
            if ($urandom_range(1)) val = ~val;
          end
        endcase
        send_op(act, val);
      end
      if (phase % 6 == 5) wait_drained();
    end

    wait_drained();
    repeat (5) @(negedge clk);
    if (tracker.expected_reports.size() != 0) begin
      tracker.mismatches++;
      $error("%0d results never arrived", tracker.expected_reports.size());
    end

    $display("covered %0d inserts (%0d dropped on full), %0d removes (%0d on empty)",
             tracker.num_inserts, tracker.num_full_drops,
             tracker.num_removes, tracker.num_empty_removes);
    $display("checked %0d results, %0d field mismatches",
             tracker.num_checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
